>>> hdl/c3sf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package c3sf_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_WIDTH_DEF   = 2048;
	localparam int COEF_BITS_DEF   = 16;
	localparam int COEF_FRAC_DEF   = 8;
	localparam int QUEUE_DEPTH_DEF = 4;

	// Configuration port geometry
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 48;
	localparam int KERNEL_W    = 48;
	localparam int WIDTH_W     = 12;
	localparam int HEIGHT_W    = 16;

	// Register reset values
	localparam logic [KERNEL_W-1:0] KERNEL_TOP_RST    = 48'h0;
	localparam logic [KERNEL_W-1:0] KERNEL_MIDDLE_RST = 48'h0000_0100_0000;
	localparam logic [KERNEL_W-1:0] KERNEL_BOTTOM_RST = 48'h0;
	localparam logic [WIDTH_W-1:0]  IMAGE_WIDTH_RST   = 12'd640;
	localparam logic [HEIGHT_W-1:0] IMAGE_HEIGHT_RST  = 16'd480;

	// Luminance weights over 2^16, with rounding term
	localparam int unsigned LUMA_R     = 19595;
	localparam int unsigned LUMA_G     = 38470;
	localparam int unsigned LUMA_B     = 7471;
	localparam int unsigned LUMA_ROUND = 32768;

	localparam int OFFSET_VALUE = 127;

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_KERNEL_TOP    = 3'd0,
		REG_KERNEL_MIDDLE = 3'd1,
		REG_KERNEL_BOTTOM = 3'd2,
		REG_LUMA_MODE     = 3'd3,
		REG_ADD_OFFSET    = 3'd4,
		REG_IMAGE_WIDTH   = 3'd5,
		REG_IMAGE_HEIGHT  = 3'd6
	} cfg_reg_e;

	typedef struct packed {
		logic [KERNEL_W-1:0] kernel_top_row;
		logic [KERNEL_W-1:0] kernel_middle_row;
		logic [KERNEL_W-1:0] kernel_bottom_row;
		logic                luminance_mode;
		logic                add_offset;
		logic [WIDTH_W-1:0]  image_width;
		logic [HEIGHT_W-1:0] image_height;
	} cfg_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} in_t;

	typedef struct packed {
		logic [7:0] chan_blue_or_luma;
		logic [7:0] chan_green;
		logic [7:0] chan_red;
		logic       frame_last;
	} out_t;

	// Two stored rows at one column
	typedef struct packed {
		in_t upper;
		in_t lower;
	} lp_t;

	// Full 3x3 window, index = column * 3 + row, column 0 oldest, row 0 top
	typedef struct packed {
		in_t [8:0] px;
		logic      last;
	} win_item_t;

	typedef struct packed {
		logic busy;
		logic emit;
	} front_stat_t;

endpackage

`default_nettype wire

>>> hdl/c3sf_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module c3sf_regs import c3sf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	// Decode the index and latch the addressed register; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kernel_top_row    <= KERNEL_TOP_RST;
			cfg_q.kernel_middle_row <= KERNEL_MIDDLE_RST;
			cfg_q.kernel_bottom_row <= KERNEL_BOTTOM_RST;
			cfg_q.luminance_mode    <= 1'b0;
			cfg_q.add_offset        <= 1'b0;
			cfg_q.image_width       <= IMAGE_WIDTH_RST;
			cfg_q.image_height      <= IMAGE_HEIGHT_RST;
		end else if (cfg_valid) begin
			case (cfg_reg_e'(cfg_index))
				REG_KERNEL_TOP:    cfg_q.kernel_top_row    <= KERNEL_W'(cfg_data);
				REG_KERNEL_MIDDLE: cfg_q.kernel_middle_row <= KERNEL_W'(cfg_data);
				REG_KERNEL_BOTTOM: cfg_q.kernel_bottom_row <= KERNEL_W'(cfg_data);
				REG_LUMA_MODE:     cfg_q.luminance_mode    <= cfg_data[0];
				REG_ADD_OFFSET:    cfg_q.add_offset        <= cfg_data[0];
				REG_IMAGE_WIDTH:   cfg_q.image_width       <= cfg_data[WIDTH_W-1:0];
				REG_IMAGE_HEIGHT:  cfg_q.image_height      <= cfg_data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> hdl/c3sf_front.sv
`timescale 1ns / 1ps
`default_nettype none

module c3sf_front import c3sf_pkg::*; #(
	parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  cfg_t                               cfg,
	input  logic                               push,
	output logic                               full,
	input  in_t                                pixel,
	input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   q_count,
	output logic                               q_push,
	output win_item_t                          q_data,
	output front_stat_t                        stat
);

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int WW   = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;
	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

	logic [CW-1:0]       col_q;
	logic [HEIGHT_W-1:0] row_q;
	logic                s1_valid;
	logic                s1_emit;
	logic                s1_last;
	logic [CW-1:0]       s1_col;
	in_t                 s1_pix;
	lp_t                 rd_q;
	in_t                 win_q [6];
	lp_t                 line_mem [MAX_WIDTH];

	logic                accept;
	logic [CNTW:0]       used;
	logic [WW-1:0]       w_raw;
	logic [WW-1:0]       w_eff;
	logic [HEIGHT_W-1:0] h_eff;
	logic                col_end;
	logic                row_end;

	// Reserve a queue slot for the transaction held in stage 1
	assign used   = {1'b0, q_count} + (CNTW + 1)'(s1_valid);
	assign full   = used >= (CNTW + 1)'(QUEUE_DEPTH);
	assign accept = push && !full;

	// Clamp frame size to the supported range
	always_comb begin
		w_raw = WW'(cfg.image_width);
		if (w_raw < WW'(3))
			w_eff = WW'(3);
		else if (w_raw > WW'(MAX_WIDTH))
			w_eff = WW'(MAX_WIDTH);
		else
			w_eff = w_raw;
		h_eff = (cfg.image_height < HEIGHT_W'(3)) ? HEIGHT_W'(3) : cfg.image_height;
	end

	assign col_end = WW'(col_q) >= (w_eff - WW'(1));
	assign row_end = row_q >= (h_eff - HEIGHT_W'(1));

	// Advance raster position on each accepted pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			s1_valid <= 1'b0;
		end else begin
			s1_valid <= accept;
			if (accept) begin
				if (col_end) begin
					col_q <= '0;
					row_q <= row_end ? '0 : row_q + HEIGHT_W'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	// Capture pixel and its window classification
	always_ff @(posedge clk) begin
		if (accept) begin
			s1_pix  <= pixel;
			s1_col  <= col_q;
			s1_emit <= (row_q >= HEIGHT_W'(2)) && (col_q >= CW'(2));
			s1_last <= col_end && row_end;
		end
	end

	// Line memory: read on accept, write back the shifted column in the following cycle
	always_ff @(posedge clk) begin
		if (accept)
			rd_q <= line_mem[col_q];
		if (s1_valid)
			line_mem[s1_col] <= lp_t'{upper: rd_q.lower, lower: s1_pix};
	end

	// Assemble the window
	always_comb begin
		for (int k = 0; k < 6; k++)
			q_data.px[k] = win_q[k];
		q_data.px[6] = rd_q.upper;
		q_data.px[7] = rd_q.lower;
		q_data.px[8] = s1_pix;
		q_data.last  = s1_last;
	end

	assign q_push = s1_valid && s1_emit;

	// Shift window by one column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 6; k++)
				win_q[k] <= '0;
		end else if (s1_valid) begin
			for (int k = 0; k < 6; k++)
				win_q[k] <= q_data.px[k+3];
		end
	end

	assign stat.busy = s1_valid;
	assign stat.emit = q_push;

endmodule

`default_nettype wire

>>> hdl/c3sf_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module c3sf_queue import c3sf_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  win_item_t                    wdata,
	input  logic                         pop,
	output win_item_t                    rdata,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PW   = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH + 1);

	win_item_t     slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CNTW-1:0] count_q;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		next_ptr = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	// Store entries
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= wdata;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			count_q <= count_q + CNTW'(push) - CNTW'(pop);
		end
	end

	assign rdata = slot_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

endmodule

`default_nettype wire

>>> hdl/c3sf_back.sv
`timescale 1ns / 1ps
`default_nettype none

module c3sf_back import c3sf_pkg::*; #(
	parameter int COEF_BITS      = COEF_BITS_DEF,
	parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      q_empty,
	input  win_item_t q_data,
	output logic      q_pop,
	input  logic      pop,
	output logic      empty,
	output out_t      result
);

	localparam int PW  = COEF_BITS + 9;
	localparam int RW  = PW + 2;
	localparam int AW0 = (COEF_BITS + 12 > COEF_FRAC_BITS + 8) ? COEF_BITS + 12
		: COEF_FRAC_BITS + 8;
	localparam int AW  = AW0 + 1;
	localparam int KXW = 3 * COEF_BITS;
	localparam logic signed [AW-1:0] OFF_FIX = AW'(OFFSET_VALUE) << COEF_FRAC_BITS;
	localparam logic signed [AW-1:0] MAX_PIX = AW'(255);

	logic                 en;
	logic                 vld_s1, vld_s2, vld_s3, res_valid_q;
	logic                 last_s1, last_s2, last_s3;
	logic [7:0]           val_s1  [9][3];
	logic signed [PW-1:0] prod_s2 [3][9];
	logic signed [RW-1:0] rsum_s3 [3][3];
	out_t                 res_q;

	logic [KXW-1:0]              kx [3];
	logic signed [COEF_BITS-1:0] coef [9];
	logic [7:0]                  val_c [9][3];
	logic signed [AW-1:0]        total [3];
	logic [7:0]                  fin [3];

	function automatic logic [7:0] luma_of(input in_t p);
		logic [24:0] s;
		s = 25'(LUMA_B) * 25'(p.blue) + 25'(LUMA_G) * 25'(p.green)
			+ 25'(LUMA_R) * 25'(p.red) + 25'(LUMA_ROUND);
		luma_of = s[24] ? 8'hFF : s[23:16];
	endfunction

	function automatic logic [7:0] clamp_pix(input logic signed [AW-1:0] acc);
		logic signed [AW-1:0] sh;
		sh = acc >>> COEF_FRAC_BITS;
		if (acc < 0)
			clamp_pix = 8'd0;
		else if (sh > MAX_PIX)
			clamp_pix = 8'hFF;
		else
			clamp_pix = sh[7:0];
	endfunction

	// Whole pipeline advances while the result register can move
	assign en    = !res_valid_q || pop;
	assign q_pop = en && !q_empty;

	// Flip the kernel: window column j, row i uses kernel row 2-i, column 2-j
	always_comb begin
		kx[0] = KXW'(cfg.kernel_top_row);
		kx[1] = KXW'(cfg.kernel_middle_row);
		kx[2] = KXW'(cfg.kernel_bottom_row);
		for (int j = 0; j < 3; j++)
			for (int i = 0; i < 3; i++)
				coef[j*3+i] = kx[2-i][(2-j)*COEF_BITS +: COEF_BITS];
	end

	// Stage 1 operands: colors or luminance
	always_comb begin
		for (int k = 0; k < 9; k++) begin
			if (cfg.luminance_mode) begin
				val_c[k][0] = luma_of(q_data.px[k]);
				val_c[k][1] = 8'd0;
				val_c[k][2] = 8'd0;
			end else begin
				val_c[k][0] = q_data.px[k].blue;
				val_c[k][1] = q_data.px[k].green;
				val_c[k][2] = q_data.px[k].red;
			end
		end
	end

	// Stage 4 combine, offset and clamp
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			total[ch] = AW'(rsum_s3[ch][0]) + AW'(rsum_s3[ch][1]) + AW'(rsum_s3[ch][2])
				+ (cfg.add_offset ? OFF_FIX : AW'(0));
			fin[ch] = clamp_pix(total[ch]);
		end
	end

	// Hold stage valids under stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (en) begin
			vld_s1      <= !q_empty;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			res_valid_q <= vld_s3;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (en) begin
			val_s1  <= val_c;
			last_s1 <= q_data.last;
			for (int ch = 0; ch < 3; ch++)
				for (int k = 0; k < 9; k++)
					prod_s2[ch][k] <= PW'(coef[k]) * PW'(signed'({1'b0, val_s1[k][ch]}));
			last_s2 <= last_s1;
			for (int ch = 0; ch < 3; ch++)
				for (int j = 0; j < 3; j++)
					rsum_s3[ch][j] <= RW'(prod_s2[ch][j*3]) + RW'(prod_s2[ch][j*3+1])
						+ RW'(prod_s2[ch][j*3+2]);
			last_s3 <= last_s2;
			res_q.chan_blue_or_luma <= fin[0];
			res_q.chan_green        <= cfg.luminance_mode ? 8'd0 : fin[1];
			res_q.chan_red          <= cfg.luminance_mode ? 8'd0 : fin[2];
			res_q.frame_last        <= last_s3;
		end
	end

	assign empty  = !res_valid_q;
	assign result = res_q;

endmodule

`default_nettype wire

>>> hdl/conv3x3_stream_filter.sv
// A completed window passes the classify stage, the window queue, the back-end stages and the result register.
// Throughput: one pixel per cycle while full is low; the line memory is read in the accept cycle and
//   written back on the next, one port each, and the filter datapath is fully pipelined.
// Row 0, row 1, column 0 and column 1 of each frame produce no result.
// Reset (arst_n low, asynchronous): counters, window, queue and result valid flag clear; registers
//   return to identity kernel, 640x480, color mode, no offset. Line memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module conv3x3_stream_filter import c3sf_pkg::*; #(
	parameter int MAX_WIDTH      = MAX_WIDTH_DEF,
	parameter int COEF_BITS      = COEF_BITS_DEF,
	parameter int COEF_FRAC_BITS = COEF_FRAC_DEF,
	parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  in_t                    pixel,
	input  logic                   pop,
	output logic                   empty,
	output out_t                   result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

	cfg_t            cfg;
	logic            q_push;
	logic            q_pop;
	logic            q_empty;
	logic [CNTW-1:0] q_count;
	win_item_t       q_wdata;
	win_item_t       q_rdata;
	front_stat_t     front_stat;

	assign cfg_ready = 1'b1;

	c3sf_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	c3sf_front #(
		.MAX_WIDTH   (MAX_WIDTH),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.push    (push),
		.full    (full),
		.pixel   (pixel),
		.q_count (q_count),
		.q_push  (q_push),
		.q_data  (q_wdata),
		.stat    (front_stat)
	);

	c3sf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty),
		.count  (q_count)
	);

	c3sf_back #(
		.COEF_BITS      (COEF_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_empty (q_empty),
		.q_data  (q_rdata),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

	// Queue never takes a window when all slots are taken
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		front_stat.emit |-> (q_count < CNTW'(QUEUE_DEPTH)))
		else $error("window queue overflow");

	// An accepted pixel occupies the classify stage on the next cycle
	a_accept_tracked: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> front_stat.busy)
		else $error("accepted pixel lost before classify stage");

	// Back end never drains an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("window queue underflow");

endmodule

`default_nettype wire
